// File: design/dqsr_pkg.sv
// Shared types and constants for the deque with search and remove.
// Used by dqsr_cell and deque_with_search_remove; depends on nothing.
`default_nettype none

package dqsr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;

   // Request codes.
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_CONTAINS   = 3'd4;
   localparam logic [2:0] REQ_REMOVE     = 3'd5;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_POP_BACK,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY,
      S_REPORT
   } state_type;

endpackage

`default_nettype wire

// File: design/dqsr_cell.sv
// One storage cell of the deque chain: an entry, its valid bit and its match flag.
// Depends on dqsr_pkg for the command struct and cell operations.
`default_nettype none

module dqsr_cell (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dqsr_pkg::cell_cmd_type                cmd,
   input  wire logic signed [dqsr_pkg::VALUE_W-1:0]   left_data,
   input  wire logic                                  left_valid,
   input  wire logic signed [dqsr_pkg::VALUE_W-1:0]   right_data,
   input  wire logic                                  right_valid,
   input  wire logic                                  seen_in,
   output logic signed [dqsr_pkg::VALUE_W-1:0]        data,
   output logic                                       valid,
   output logic                                       seen_out
);

   logic signed [dqsr_pkg::VALUE_W-1:0] data_ff, data_in;
   logic                                valid_ff, valid_in;
   logic                                match_ff, match_in;

   // A match at or ahead of this cell means this cell closes the gap on a removal.
   assign seen_out = seen_in | match_ff;
   assign data     = data_ff;
   assign valid    = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      case (cmd.op)
         dqsr_pkg::CELL_COMPARE: begin
            match_in = valid_ff && (data_ff == cmd.value);
         end
         dqsr_pkg::CELL_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         dqsr_pkg::CELL_PUSH_BACK: begin
            if (!valid_ff && left_valid) begin
               data_in  = cmd.value;
               valid_in = 1'b1;
            end
         end
         dqsr_pkg::CELL_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         dqsr_pkg::CELL_POP_BACK: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         dqsr_pkg::CELL_REMOVE: begin
            if (seen_out) begin
               data_in  = right_data;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

// File: design/deque_with_search_remove.sv
// Top level of the bounded deque with search and remove: control sequencer,
// cell chain and result register. Depends on dqsr_pkg and dqsr_cell.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_type, req_item_value
//   rsp     | out       | rsp_valid / rsp_ready | front, back, entry_total, found, status
//
// A request goes through its steps in order: accept, compare in every cell, apply the shift
// across the chain, and load the result register; the sequencer runs one request at a time.
// The next request is accepted while a result still waits in the output register.
// Reset empties the deque at once by clearing every cell's valid bit.
// A stalled result channel holds the sequencer in its report step until the register frees.
`default_nettype none

module deque_with_search_remove #(
   parameter int DEPTH = dqsr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_type,
   input  wire logic signed [dqsr_pkg::VALUE_W-1:0] req_item_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [dqsr_pkg::VALUE_W-1:0]      rsp_front_value,
   output logic signed [dqsr_pkg::VALUE_W-1:0]      rsp_back_value,
   output logic [4:0]                               rsp_entry_total,
   output logic                                     rsp_found,
   output logic [1:0]                               rsp_status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dqsr_pkg::state_type state_ff, state_in;

   logic [2:0]                          op_ff, op_in;
   logic signed [dqsr_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [1:0]                          status_ff, status_in;
   logic                                found_ff, found_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [dqsr_pkg::VALUE_W-1:0] rsp_front_ff, rsp_back_ff;
   logic [4:0]                          rsp_total_ff;
   logic                                rsp_found_ff;
   logic [1:0]                          rsp_status_ff;

   logic                                load_rsp;
   dqsr_pkg::cell_op_type               apply_op;
   dqsr_pkg::cell_cmd_type              cmd;

   logic signed [dqsr_pkg::VALUE_W-1:0] cell_data  [DEPTH];
   logic                                cell_valid [DEPTH];
   logic                                seen       [DEPTH+1];
   logic signed [dqsr_pkg::VALUE_W-1:0] back_part  [DEPTH];

   logic signed [dqsr_pkg::VALUE_W-1:0] front_now, back_now;
   logic                                empty, full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_FULL);

   // ---------------- cell chain ----------------
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [dqsr_pkg::VALUE_W-1:0] left_d, right_d;
      logic                                left_v, right_v, is_last;

      if (i == 0) begin : g_head
         assign left_d = value_ff;
         assign left_v = 1'b1;
      end else begin : g_mid_left
         assign left_d = cell_data[i-1];
         assign left_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_d = '0;
         assign right_v = 1'b0;
      end else begin : g_mid_right
         assign right_d = cell_data[i+1];
         assign right_v = cell_valid[i+1];
      end

      assign is_last      = cell_valid[i] && !right_v;
      assign back_part[i] = cell_data[i] & {dqsr_pkg::VALUE_W{is_last}};

      dqsr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (left_d),
         .left_valid  (left_v),
         .right_data  (right_d),
         .right_valid (right_v),
         .seen_in     (seen[i]),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .seen_out    (seen[i+1])
      );
   end

   // At most one cell is the back entry (none when empty), so an OR over the masked entries selects it.
   always_comb begin
      back_now = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_now = back_now | back_part[i];
      end
      front_now = cell_data[0] & {dqsr_pkg::VALUE_W{cell_valid[0]}};
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      apply_op  = dqsr_pkg::CELL_HOLD;
      load_rsp  = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         dqsr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_type;
               value_in = req_item_value;
               state_in = dqsr_pkg::S_COMPARE;
            end
         end
         dqsr_pkg::S_COMPARE: begin
            state_in = dqsr_pkg::S_APPLY;
         end
         dqsr_pkg::S_APPLY: begin
            status_in = dqsr_pkg::STATUS_OK;
            found_in  = 1'b0;
            case (op_ff)
               dqsr_pkg::REQ_PUSH_FRONT, dqsr_pkg::REQ_PUSH_BACK: begin
                  if (full) begin
                     status_in = dqsr_pkg::STATUS_FULL;
                  end else begin
                     apply_op = (op_ff == dqsr_pkg::REQ_PUSH_FRONT) ?
                                dqsr_pkg::CELL_PUSH_FRONT : dqsr_pkg::CELL_PUSH_BACK;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               dqsr_pkg::REQ_POP_FRONT, dqsr_pkg::REQ_POP_BACK: begin
                  if (empty) begin
                     status_in = dqsr_pkg::STATUS_EMPTY;
                  end else begin
                     apply_op = (op_ff == dqsr_pkg::REQ_POP_FRONT) ?
                                dqsr_pkg::CELL_POP_FRONT : dqsr_pkg::CELL_POP_BACK;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               dqsr_pkg::REQ_CONTAINS: begin
                  if (empty) begin
                     status_in = dqsr_pkg::STATUS_EMPTY;
                  end else begin
                     found_in = seen[DEPTH];
                  end
               end
               dqsr_pkg::REQ_REMOVE: begin
                  if (empty) begin
                     status_in = dqsr_pkg::STATUS_EMPTY;
                  end else if (seen[DEPTH]) begin
                     found_in = 1'b1;
                     apply_op = dqsr_pkg::CELL_REMOVE;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
            state_in = dqsr_pkg::S_REPORT;
         end
         dqsr_pkg::S_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = dqsr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dqsr_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.value = value_ff;
      if (state_ff == dqsr_pkg::S_COMPARE) begin
         cmd.op = dqsr_pkg::CELL_COMPARE;
      end else begin
         cmd.op = apply_op;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqsr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (load_rsp) begin
         rsp_front_ff  <= front_now;
         rsp_back_ff   <= back_now;
         rsp_total_ff  <= 5'(count_ff);
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire
